FILE: rtl/fkslp_pkg.sv
package fkslp_pkg;

  localparam logic [3:0]  KEYS_RELEASED     = 4'hf;
  localparam logic [15:0] DEBOUNCE_RESET    = 16'd500;
  localparam logic [15:0] LONG_RESET        = 16'd20000;
  localparam logic [15:0] COUNT_MAX         = 16'hffff;

  localparam logic [3:0]  PATTERN_KEY1      = 4'hd;
  localparam logic [3:0]  PATTERN_KEY2      = 4'he;
  localparam logic [3:0]  PATTERN_KEY3      = 4'hb;
  localparam logic [3:0]  PATTERN_KEY4      = 4'h7;

  localparam logic [2:0]  KEY_NONE          = 3'd0;
  localparam logic [2:0]  KEY_1             = 3'd1;
  localparam logic [2:0]  KEY_2             = 3'd2;
  localparam logic [2:0]  KEY_3             = 3'd3;
  localparam logic [2:0]  KEY_4             = 3'd4;
  localparam logic [2:0]  KEY_LAST          = KEY_4;

  localparam logic [1:0]  REG_DEBOUNCE      = 2'd0;
  localparam logic [1:0]  REG_LONG          = 2'd1;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_HELD     = 2'd2,
    PH_WAIT     = 2'd3
  } phase_t;

  typedef struct packed {
    logic [15:0] debounce_ticks;
    logic [15:0] long_ticks;
  } cfg_regs_t;

  typedef struct packed {
    logic [2:0] key_number;
    logic       long_press;
  } key_event_t;

  // Map a single-key pattern to its key number; anything else is no key.
  function automatic logic [2:0] decode_key(input logic [3:0] pattern);
    logic [2:0] num;
    unique case (pattern)
      PATTERN_KEY1: num = KEY_1;
      PATTERN_KEY2: num = KEY_2;
      PATTERN_KEY3: num = KEY_3;
      PATTERN_KEY4: num = KEY_4;
      default:      num = KEY_NONE;
    endcase
    return num;
  endfunction

endpackage

FILE: rtl/fkslp_cfg.sv
module fkslp_cfg
  import fkslp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_regs_t   regs
);

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.debounce_ticks <= DEBOUNCE_RESET;
      regs.long_ticks     <= LONG_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_DEBOUNCE) begin
        regs.debounce_ticks <= cfg_data;
      end else if (cfg_index == REG_LONG) begin
        regs.long_ticks <= cfg_data;
      end
    end
  end

endmodule

FILE: rtl/fkslp_core.sv
module fkslp_core
  import fkslp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [3:0] keys,
  input  cfg_regs_t  regs,
  output key_event_t evt
);

  phase_t      phase;
  phase_t      phase_next;
  logic [15:0] hold_count;
  logic [15:0] hold_count_next;
  logic [3:0]  latched_pattern;
  logic [3:0]  latched_pattern_next;
  logic        pressed;
  logic [15:0] count_bumped;
  logic [2:0]  keys_num;

  assign pressed      = (keys != KEYS_RELEASED);
  assign count_bumped = (hold_count == COUNT_MAX) ? hold_count : hold_count + 16'd1;
  assign keys_num     = decode_key(keys);

  // Next state.
  always_comb begin
    phase_next           = phase;
    hold_count_next      = hold_count;
    latched_pattern_next = latched_pattern;
    unique case (phase)
      PH_IDLE: begin
        if (pressed) begin
          hold_count_next      = '0;
          latched_pattern_next = '0;
          phase_next           = PH_DEBOUNCE;
        end
      end
      PH_DEBOUNCE: begin
        if (pressed) begin
          hold_count_next = count_bumped;
          if (count_bumped > regs.debounce_ticks) begin
            latched_pattern_next = keys;
            phase_next           = PH_HELD;
          end
        end else begin
          phase_next = PH_IDLE;
        end
      end
      PH_HELD: begin
        if (!pressed) begin
          phase_next = PH_IDLE;
        end else begin
          hold_count_next = count_bumped;
          if (count_bumped > regs.long_ticks) begin
            phase_next = PH_WAIT;
          end
        end
      end
      PH_WAIT: begin
        if (!pressed) begin
          phase_next = PH_IDLE;
        end
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  // Event for this tick.
  always_comb begin
    evt.key_number = KEY_NONE;
    evt.long_press = 1'b0;
    if (phase == PH_HELD) begin
      if (!pressed) begin
        evt.key_number = decode_key(latched_pattern);
      end else if (count_bumped > regs.long_ticks) begin
        evt.key_number = keys_num;
        evt.long_press = (keys_num != KEY_NONE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      hold_count      <= '0;
      latched_pattern <= '0;
    end else if (step) begin
      phase           <= phase_next;
      hold_count      <= hold_count_next;
      latched_pattern <= latched_pattern_next;
    end
  end

endmodule

FILE: rtl/four_key_short_long_press.sv
// Four-key short/long press detector.
//
// Input channel (in_valid/in_ready, key_levels): one transfer per sampling
// tick, four active-low key lines, 4'hf when all keys are up.
// Output channel (out_valid/out_ready, key_number, long_press): exactly one
// transfer per input transfer, in order. key_number is 0 when no key event
// happened this tick, 1..4 for a short or long press; long_press marks holds
// beyond long_ticks.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 sets
// debounce_ticks, index 1 sets long_ticks, other indexes are dropped.
// Write only while no input transfer is outstanding.
//
// The result of an input transfer sits in the output register on the next
// edge. One item per cycle is sustained while the receiver keeps up; the
// output register is the only stage, and in_ready stays high while it is
// empty or being drained. When the receiver stalls, the result is held and
// in_ready drops until it is taken. Reset returns to idle with zero count
// and restores debounce_ticks = 500, long_ticks = 20000.
module four_key_short_long_press
  import fkslp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  key_levels,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  key_number,
  output logic        long_press,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_regs_t  regs;
  key_event_t evt;
  logic       in_xfer;

  // Accept whenever the result register is free or drains this cycle.
  assign in_ready  = !out_valid || out_ready;
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  fkslp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  // Advance the press machine once per accepted tick.
  fkslp_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (in_xfer),
    .keys (key_levels),
    .regs (regs),
    .evt  (evt)
  );

  // Result register: load on input transfer, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      key_number <= evt.key_number;
      long_press <= evt.long_press;
    end
  end

`ifndef SYNTHESIS
  a_long_has_key: assert property (@(posedge clk) disable iff (rst)
    out_valid && long_press |-> key_number != KEY_NONE)
    else $error("long press reported without a key");

  a_key_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> key_number <= KEY_LAST)
    else $error("key number out of range");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted tick produced no result");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && !in_ready |=> out_valid)
    else $error("stalled result lost");
`endif

endmodule

FILE: dv/four_key_short_long_press_check.sv
module four_key_short_long_press_check
  import fkslp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [3:0]  key_levels,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  key_number,
  input  logic        long_press,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int unsigned mismatch_count,
  output int unsigned outstanding,
  output int unsigned results_checked,
  output int unsigned key_reports
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [15:0] debounce_limit;
  logic [15:0] long_limit;
  phase_t      press_phase;
  logic [15:0] tick_count;
  logic [3:0]  held_pattern;
  key_event_t  pending_events[$];

  int unsigned miss_total = 0;
  int unsigned result_total = 0;
  int unsigned report_total = 0;

  assign mismatch_count  = miss_total;
  assign results_checked = result_total;
  assign key_reports     = report_total;

  function automatic logic [2:0] key_of(input logic [3:0] pattern);
    case (pattern)
      PATTERN_KEY1: return KEY_1;
      PATTERN_KEY2: return KEY_2;
      PATTERN_KEY3: return KEY_3;
      PATTERN_KEY4: return KEY_4;
      default:      return KEY_NONE;
    endcase
  endfunction

  // Advance the press tracker by one tick and return the event it reports.
  function automatic key_event_t track_press(input logic [3:0] levels);
    key_event_t ev;
    logic       down;
    ev.key_number = KEY_NONE;
    ev.long_press = 1'b0;
    down = (levels != KEYS_RELEASED);
    case (press_phase)
      PH_IDLE: begin
        if (down) begin
          tick_count   = '0;
          held_pattern = '0;
          press_phase  = PH_DEBOUNCE;
        end
      end
      PH_DEBOUNCE: begin
        if (!down) begin
          press_phase = PH_IDLE;
        end else begin
          if (tick_count != COUNT_MAX) tick_count = tick_count + 16'd1;
          if (tick_count > debounce_limit) begin
            held_pattern = levels;
            press_phase  = PH_HELD;
          end
        end
      end
      PH_HELD: begin
        if (!down) begin
          ev.key_number = key_of(held_pattern);
          press_phase   = PH_IDLE;
        end else begin
          if (tick_count != COUNT_MAX) tick_count = tick_count + 16'd1;
          if (tick_count > long_limit) begin
            ev.key_number = key_of(levels);
            ev.long_press = (ev.key_number != KEY_NONE);
            press_phase   = PH_WAIT;
          end
        end
      end
      default: begin
        if (!down) press_phase = PH_IDLE;
      end
    endcase
    return ev;
  endfunction

  always @(posedge clk) begin
    key_event_t want;
    if (rst) begin
      debounce_limit = DEBOUNCE_RESET;
      long_limit     = LONG_RESET;
      press_phase    = PH_IDLE;
      tick_count     = '0;
      held_pattern   = '0;
      pending_events.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DEBOUNCE: debounce_limit = cfg_data;
          REG_LONG:     long_limit     = cfg_data;
          default:      ;
        endcase
      end
      if (in_valid && in_ready) pending_events.push_back(track_press(key_levels));
      if (out_valid && out_ready) begin
        result_total++;
        if (key_number !== KEY_NONE) report_total++;
        if (pending_events.size() == 0) begin
          $error("unexpected result: key_number=%0d long_press=%0d", key_number, long_press);
          miss_total++;
        end else begin
          want = pending_events.pop_front();
          if (key_number !== want.key_number) begin
            $error("key_number: expected %0d, got %0d", want.key_number, key_number);
            miss_total++;
          end
          if (long_press !== want.long_press) begin
            $error("long_press: expected %0d, got %0d", want.long_press, long_press);
            miss_total++;
          end
        end
      end
    end
    outstanding <= pending_events.size();
  end

endmodule

FILE: dv/four_key_short_long_press_test.sv
module four_key_short_long_press_test;
  timeunit 1ns;
  timeprecision 1ps;
  import fkslp_pkg::*;

  // Indexes past the register list; writes to them must be dropped.
  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;

  // Length of the forced output stall, in clock cycles.
  localparam int unsigned RX_HOLD_CYCLES = 60;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic [3:0]  key_levels = KEYS_RELEASED;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic [2:0]  key_number;
  logic        long_press;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index  = REG_DEBOUNCE;
  logic [15:0] cfg_data   = '0;

  int unsigned mismatch_count;
  int unsigned outstanding;
  int unsigned results_checked;
  int unsigned key_reports;

  // Idle mix: sender percentage is used only by the stimulus process,
  // receiver percentage is handed over with nonblocking writes.
  int unsigned tx_idle_pct  = 11;
  int unsigned rx_idle_pct  = 56;
  bit          rx_hold_req  = 1'b0;
  int unsigned samples_sent = 0;

  // Thresholds currently programmed, used to shape press lengths.
  int unsigned cur_debounce = DEBOUNCE_RESET;
  int unsigned cur_long     = LONG_RESET;

  four_key_short_long_press dut (.*);

  four_key_short_long_press_check keypad_check (.*);

  always #4ns clk = ~clk;

  // Hard stop in case the block wedges.
  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

  // Receiver: random backpressure, plus a long stall whenever the stimulus
  // flips rx_hold_req. The stall is counted here, independent of the sender.
  initial begin : rx_side
    bit seen_req;
    seen_req = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req != seen_req) begin
        seen_req = rx_hold_req;
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Offer one tick of key levels and hold it until the transfer happens.
  // Valid is left high on return so back-to-back samples never glitch it;
  // the next call either replaces the payload or drops valid for a gap.
  task automatic offer(input logic [3:0] levels);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < tx_idle_pct) @(posedge clk);
    end
    in_valid   <= 1'b1;
    key_levels <= levels;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    samples_sent++;
  endtask

  // Drop valid and hold off until every predicted result has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Reprogram both thresholds once the block has gone quiet.
  task automatic set_limits(input logic [15:0] debounce, input logic [15:0] hold_long);
    drain();
    write_reg(REG_DEBOUNCE, debounce);
    write_reg(REG_LONG, hold_long);
    cur_debounce = debounce;
    cur_long     = hold_long;
  endtask

  // Hold a pattern for a number of ticks; jitter swaps in random pressed
  // patterns (single or multi-key) to mimic contact bounce.
  task automatic hold_keys(input logic [3:0] pattern, input int unsigned ticks,
                           input int unsigned jitter_pct);
    logic [3:0] lv;
    for (int unsigned i = 0; i < ticks; i++) begin
      lv = pattern;
      if ($urandom_range(0, 99) < jitter_pct) lv = 4'($urandom_range(0, 14));
      offer(lv);
    end
  endtask

  // Mostly well-formed presses with random key and length, aimed at both
  // thresholds; the rest are bounces, multi-key chords and jittery holds.
  task automatic random_presses(input int unsigned count);
    int unsigned stop_at;
    int unsigned span;
    int unsigned ticks;
    int unsigned base;
    logic [3:0]  pattern;
    stop_at = samples_sent + count;
    while (samples_sent < stop_at) begin
      span = ((cur_debounce > cur_long) ? cur_debounce : cur_long) + 4;
      case ($urandom_range(0, 3))
        0:       pattern = PATTERN_KEY1;
        1:       pattern = PATTERN_KEY2;
        2:       pattern = PATTERN_KEY3;
        default: pattern = PATTERN_KEY4;
      endcase
      if ($urandom_range(0, 9) == 0) pattern = 4'($urandom_range(0, 14));
      if ($urandom_range(0, 9) < 3) begin
        // land right on a latch or long-press boundary
        base  = $urandom_range(0, 1) ? cur_debounce + 1 : cur_long + 2;
        ticks = base - 1 + $urandom_range(0, 2);
      end else begin
        ticks = $urandom_range(0, span);
      end
      hold_keys(pattern, ticks, $urandom_range(0, 1) ? 0 : 10);
      repeat ($urandom_range(0, 3)) offer(KEYS_RELEASED);
    end
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset thresholds: a brief press must stay far below the debounce count.
    hold_keys(PATTERN_KEY1, 12, 0);
    offer(KEYS_RELEASED);

    // Writes past the register list must change nothing.
    drain();
    write_reg(REG_SPARE_A, 16'hffff);
    write_reg(REG_SPARE_B, 16'h0000);

    // Tight thresholds: latch on the second pressed tick, long on the third.
    set_limits(16'd0, 16'd1);
    hold_keys(PATTERN_KEY1, 2, 0);
    offer(KEYS_RELEASED);
    hold_keys(PATTERN_KEY2, 2, 0);
    offer(KEYS_RELEASED);
    hold_keys(PATTERN_KEY3, 2, 0);
    offer(KEYS_RELEASED);
    hold_keys(PATTERN_KEY4, 2, 0);
    offer(KEYS_RELEASED);
    // plain long press
    hold_keys(PATTERN_KEY2, 3, 0);
    offer(KEYS_RELEASED);
    // long press reports the key down now, not the latched one
    hold_keys(PATTERN_KEY1, 2, 0);
    offer(PATTERN_KEY4);
    offer(KEYS_RELEASED);
    // chord at long time reports nothing, then idle in wait-for-release
    hold_keys(PATTERN_KEY3, 2, 0);
    offer(4'h0);
    offer(PATTERN_KEY3);
    offer(KEYS_RELEASED);
    // chord latched, released early: short press of no key
    hold_keys(4'h5, 2, 0);
    offer(KEYS_RELEASED);

    // Sender idles lightly, receiver heavily.
    set_limits(16'd0, 16'd0);
    random_presses(110);
    repeat (2) begin
      set_limits(16'($urandom_range(0, 8)), 16'($urandom_range(0, 24)));
      random_presses(110);
    end

    // Swap the idle mix.
    drain();
    tx_idle_pct = 56;
    rx_idle_pct <= 11;
    set_limits(16'd6, 16'd2);
    random_presses(110);
    // Stall the output for a long stretch while samples keep coming.
    rx_hold_req <= ~rx_hold_req;
    random_presses(25);
    repeat (2) begin
      set_limits(16'($urandom_range(0, 8)), 16'($urandom_range(0, 24)));
      random_presses(110);
    end

    // Full rate both ways.
    drain();
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    repeat (3) begin
      set_limits(16'($urandom_range(0, 8)), 16'($urandom_range(0, 24)));
      random_presses(110);
    end

    // Top of range: with both limits near the ceiling a short hold never
    // latches, and the release reports nothing.
    set_limits(16'd65534, 16'd65534);
    hold_keys(PATTERN_KEY3, 40, 0);
    offer(KEYS_RELEASED);
    offer(KEYS_RELEASED);

    drain();
    $display("Sent %0d key samples; %0d results checked, %0d of them key reports.",
             samples_sent, results_checked, key_reports);
    $display("Thresholds ran from reset values through zero, inverted, random and top of range.");
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: four_key_short_long_press.f
rtl/fkslp_pkg.sv
rtl/fkslp_cfg.sv
rtl/fkslp_core.sv
rtl/four_key_short_long_press.sv
dv/four_key_short_long_press_check.sv
dv/four_key_short_long_press_test.sv
